@@ hdl/lpo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpo_pkg
// Shared types, constants and helpers for the Leja point ordering block.
// ----------------------------------------------------------------------------
package lpo_pkg;

  localparam int LPO_MAX_POINTS = 32;

  localparam logic [63:0] FP_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] FP_PINF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FP_ZERO = 64'h0000_0000_0000_0000;

  typedef enum logic {
    FP_SUB = 1'b0,  // |a - b|
    FP_MUL = 1'b1   // a * b, both non-negative
  } fp_op_t;

  typedef struct packed {
    logic        start;
    fp_op_t      op;
    logic [63:0] a;
    logic [63:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fp_rsp_t;

  // sign is ignored
  function automatic logic fp_is_nan(input logic [63:0] x);
    fp_is_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

endpackage
`default_nettype wire

@@ hdl/lpo_fp_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpo_fp_unit
// Multi-cycle double unit: |a-b| or a*b, round to nearest even, with one
// shared normalize and round sequence (one bit shift per cycle; the denormal shift moves all its bits at once).
// ----------------------------------------------------------------------------
module lpo_fp_unit import lpo_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire fp_req_t req,
  output fp_rsp_t      rsp
);

  localparam int MW = 108;  // leading one lives at bit 105

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_ALIGN = 5'b00010,
    F_ADD   = 5'b00100,
    F_MUL   = 5'b01000,
    F_NORM  = 5'b10000
  } fstate_t;

  fstate_t state;

  logic [MW-1:0]      m, xm, ys;
  logic               sticky;
  logic signed [12:0] e;
  logic [10:0]        d;
  logic               eff_sub;
  logic [52:0]        sa, sb;
  logic [53:0]        pp;
  logic [5:0]         pp_sh;
  logic [2:0]         k;
  logic [63:0]        res;
  logic               done;

  // operand unpack
  logic [10:0] ea, eb, ee_a, ee_b;
  logic [52:0] sig_a, sig_b;
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan, a_ge, same_sign;

  assign ea        = req.a[62:52];
  assign eb        = req.b[62:52];
  assign ee_a      = (ea == 11'd0) ? 11'd1 : ea;
  assign ee_b      = (eb == 11'd0) ? 11'd1 : eb;
  assign sig_a     = {ea != 11'd0, req.a[51:0]};
  assign sig_b     = {eb != 11'd0, req.b[51:0]};
  assign a_zero    = (req.a[62:0] == 63'd0);
  assign b_zero    = (req.b[62:0] == 63'd0);
  assign a_inf     = (ea == 11'h7FF) && (req.a[51:0] == 52'd0);
  assign b_inf     = (eb == 11'h7FF) && (req.b[51:0] == 52'd0);
  assign a_nan     = fp_is_nan(req.a);
  assign b_nan     = fp_is_nan(req.b);
  assign a_ge      = (req.a[62:0] >= req.b[62:0]);
  assign same_sign = (req.a[63] == req.b[63]);

  // alignment of the smaller operand, shifted-out bits jammed into bit 0
  logic          d_big, al_jam;
  logic [MW-1:0] al_mask, al_val;
  assign d_big   = (d > 11'd107);
  assign al_mask = ~({MW{1'b1}} << d[6:0]);
  assign al_jam  = d_big ? (|ys) : (|(ys & al_mask));
  assign al_val  = d_big ? '0 : (ys >> d[6:0]);

  // partial product select: 27-bit halves
  logic [26:0] mul_a, mul_b;
  logic [5:0]  sh_k;
  assign mul_a = (k == 3'd2 || k == 3'd3) ? {1'b0, sa[52:27]} : sa[26:0];
  assign mul_b = (k == 3'd1 || k == 3'd3) ? {1'b0, sb[52:27]} : sb[26:0];
  assign sh_k  = (k == 3'd0) ? 6'd0 : ((k == 3'd3) ? 6'd54 : 6'd27);

  // denormal shift
  logic signed [12:0] uf_sh;
  logic               uf_big;
  logic [MW-1:0]      uf_mask;
  assign uf_sh   = 13'sd1 - e;
  assign uf_big  = (uf_sh > 13'sd107);
  assign uf_mask = ~({MW{1'b1}} << uf_sh[6:0]);

  // round and pack; carry out of the fraction bumps the exponent
  logic [10:0] exp_field;
  logic        rnd_inc;
  logic [63:0] packed_res;
  assign exp_field  = m[105] ? e[10:0] : 11'd0;
  assign rnd_inc    = m[52] & ((|m[51:0]) | sticky | m[53]);
  assign packed_res = {1'b0, exp_field, m[104:53]} + 64'(rnd_inc);

  // NaN or infinity operands, and for a multiply also zero operands, finish straight from idle
  logic sub_special, mul_special, norm_done, done_next;
  assign sub_special = a_nan || b_nan || a_inf || b_inf;
  assign mul_special = sub_special || a_zero || b_zero;
  // normalize ends when no shift and no denormal step is left to do
  assign norm_done   = (m[107:106] == 2'b00) &&
                       ((m == '0) || ((m[105] || (e <= 13'sd1)) && (e >= 13'sd1)));

  always_comb begin
    case (state)
      F_IDLE:  done_next = req.start &&
                           ((req.op == FP_SUB) ? sub_special : mul_special);
      F_NORM:  done_next = norm_done;
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        F_IDLE: begin
          if (req.start) begin
            sticky <= 1'b0;
            if (req.op == FP_SUB) begin
              if (a_nan || b_nan || (a_inf && b_inf && same_sign)) begin
                res <= FP_QNAN;
              end else if (a_inf || b_inf) begin
                res <= FP_PINF;
              end else begin
                xm      <= {2'b00, (a_ge ? sig_a : sig_b), 53'd0};
                ys      <= {2'b00, (a_ge ? sig_b : sig_a), 53'd0};
                d       <= a_ge ? (ee_a - ee_b) : (ee_b - ee_a);
                e       <= $signed({2'b00, (a_ge ? ee_a : ee_b)});
                eff_sub <= same_sign;
                state   <= F_ALIGN;
              end
            end else begin
              if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                res <= FP_QNAN;
              end else if (a_inf || b_inf) begin
                res <= FP_PINF;
              end else if (a_zero || b_zero) begin
                res <= FP_ZERO;
              end else begin
                sa    <= sig_a;
                sb    <= sig_b;
                e     <= $signed({2'b00, ee_a}) + $signed({2'b00, ee_b}) - 13'sd1022;
                m     <= '0;
                k     <= 3'd0;
                state <= F_MUL;
              end
            end
          end
        end
        F_ALIGN: begin
          ys    <= {al_val[MW-1:1], al_val[0] | al_jam};
          state <= F_ADD;
        end
        F_ADD: begin
          m     <= eff_sub ? (xm - ys) : (xm + ys);
          state <= F_NORM;
        end
        F_MUL: begin
          if (k != 3'd0) begin
            m <= m + (MW'(pp) << pp_sh);
          end
          if (k == 3'd4) begin
            state <= F_NORM;
          end else begin
            pp    <= mul_a * mul_b;
            pp_sh <= sh_k;
            k     <= k + 3'd1;
          end
        end
        F_NORM: begin
          if (m[107:106] != 2'b00) begin
            m      <= m >> 1;
            sticky <= sticky | m[0];
            e      <= e + 13'sd1;
          end else if (m == '0) begin
            res   <= FP_ZERO;
            state <= F_IDLE;
          end else if (!m[105] && (e > 13'sd1)) begin
            m <= m << 1;
            e <= e - 13'sd1;
          end else if (e < 13'sd1) begin
            m      <= uf_big ? '0 : (m >> uf_sh[6:0]);
            sticky <= sticky | (uf_big ? (|m) : (|(m & uf_mask)));
            e      <= 13'sd1;
          end else begin
            res   <= (e > 13'sd2046) ? FP_PINF : packed_res;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule
`default_nettype wire

@@ hdl/leja_point_ordering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leja_point_ordering
// Collects a set of doubles and returns them in Leja order, driving one
// shared float subtract/multiply unit from a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid, in_stall | point_value, last_point
//  output  | out       | out_valid,out_stall| ordered_value, last_ordered
//
//  Load: one point per cycle until the last one or a full store.
//  Ordering n points: the first pick scans all points for the largest
//  magnitude; each later pick runs a subtract then a multiply in the
//  shared unit per unused point and skips used points; cancellation or
//  subnormal operands lengthen the normalize step.
//  The input stalls for the whole ordering run. Reset is synchronous.
//  A stalled output beat holds the sequencer at the emit step.
// ----------------------------------------------------------------------------
module leja_point_ordering import lpo_pkg::*; #(
  parameter int MAX_POINTS = LPO_MAX_POINTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] point_value,
  input  wire logic        last_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      ordered_value,
  output logic             last_ordered
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [9:0] {
    S_LOAD      = 10'b00_0000_0001,
    S_SCAN_RD   = 10'b00_0000_0010,
    S_SCAN_CMP  = 10'b00_0000_0100,
    S_PICK_RD   = 10'b00_0000_1000,
    S_PICK_EMIT = 10'b00_0001_0000,
    S_UPD_RD    = 10'b00_0010_0000,
    S_UPD_SUB   = 10'b00_0100_0000,
    S_UPD_SUBW  = 10'b00_1000_0000,
    S_UPD_MUL   = 10'b01_0000_0000,
    S_UPD_MULW  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [CW-1:0]         cnt, n_pts, i, r;
  logic [IW-1:0]         pick, best_idx, free_idx;
  logic                  have_free, best_valid;
  logic [62:0]           best_val;
  logic [63:0]           picked, diff;
  logic [MAX_POINTS-1:0] used;

  // storage
  logic [63:0] st_mem [MAX_POINTS];
  logic [63:0] dp_mem [MAX_POINTS];
  logic [63:0] st_q, dp_q, dp_wdata;
  logic [IW-1:0] st_raddr;
  logic          st_we, dp_we;

  logic    in_fire, emit_fire, emit_last, pass_end;
  fp_req_t fp_req;
  fp_rsp_t fp_rsp;

  assign in_stall  = (state != S_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state == S_PICK_EMIT) && (!out_valid || !out_stall);
  assign emit_last = ((r + 1'b1) == n_pts);
  assign pass_end  = ((i + 1'b1) == n_pts);

  assign st_we    = in_fire;
  assign st_raddr = (state == S_PICK_RD || state == S_PICK_EMIT) ? pick : i[IW-1:0];
  assign dp_we    = (state == S_SCAN_RD) || ((state == S_UPD_MULW) && fp_rsp.done);
  assign dp_wdata = (state == S_SCAN_RD) ? FP_ONE : fp_rsp.res;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[cnt[IW-1:0]] <= point_value;
    end
    st_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[i[IW-1:0]] <= dp_wdata;
    end
    dp_q <= dp_mem[i[IW-1:0]];
  end

  // shared arithmetic
  assign fp_req.start = (state == S_UPD_SUB) || (state == S_UPD_MUL);
  assign fp_req.op    = (state == S_UPD_MUL) ? FP_MUL : FP_SUB;
  assign fp_req.a     = (state == S_UPD_MUL) ? dp_q : st_q;
  assign fp_req.b     = (state == S_UPD_MUL) ? diff : picked;

  lpo_fp_unit u_fp (
    .clk (clk),
    .rst (rst),
    .req (fp_req),
    .rsp (fp_rsp)
  );

  // compare helpers: magnitudes and products are non-negative, so bit order works
  logic scan_take, prod_take;
  assign scan_take = (i == '0) ||
                     (!fp_is_nan(st_q) && !fp_is_nan({1'b0, best_val}) &&
                      (st_q[62:0] > best_val));
  assign prod_take = !fp_is_nan(fp_rsp.res) &&
                     (!best_valid || (fp_rsp.res[62:0] > best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (last_point || ((cnt + 1'b1) == CW'(MAX_POINTS))) begin
              n_pts <= cnt + 1'b1;
              cnt   <= '0;
              i     <= '0;
              state <= S_SCAN_RD;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (scan_take) begin
            best_val <= st_q[62:0];
            best_idx <= i[IW-1:0];
          end
          if (pass_end) begin
            pick  <= scan_take ? i[IW-1:0] : best_idx;
            r     <= '0;
            state <= S_PICK_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_PICK_RD: state <= S_PICK_EMIT;
        S_PICK_EMIT: begin
          if (emit_fire) begin
            ordered_value <= st_q;
            last_ordered  <= emit_last;
            picked        <= st_q;
            if (emit_last) begin
              used  <= '0;
              state <= S_LOAD;
            end else begin
              used[pick] <= 1'b1;
              r          <= r + 1'b1;
              i          <= '0;
              best_valid <= 1'b0;
              have_free  <= 1'b0;
              state      <= S_UPD_RD;
            end
          end
        end
        S_UPD_RD: begin
          if (used[i[IW-1:0]]) begin
            // already emitted: skip
            if (pass_end) begin
              pick  <= best_valid ? best_idx : free_idx;
              state <= S_PICK_RD;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            if (!have_free) begin
              free_idx  <= i[IW-1:0];
              have_free <= 1'b1;
            end
            state <= S_UPD_SUB;
          end
        end
        S_UPD_SUB: state <= S_UPD_SUBW;
        S_UPD_SUBW: begin
          if (fp_rsp.done) begin
            diff  <= fp_rsp.res;
            state <= S_UPD_MUL;
          end
        end
        S_UPD_MUL: state <= S_UPD_MULW;
        S_UPD_MULW: begin
          if (fp_rsp.done) begin
            if (prod_take) begin
              best_valid <= 1'b1;
              best_val   <= fp_rsp.res[62:0];
              best_idx   <= i[IW-1:0];
            end
            if (pass_end) begin
              // all products NaN: lowest unused point
              pick  <= prod_take ? i[IW-1:0] : (best_valid ? best_idx : free_idx);
              state <= S_PICK_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_UPD_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pick_unused: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> !used[pick])
    else $error("emitting a point already used");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (n_pts != '0) && (n_pts <= CW'(MAX_POINTS)))
    else $error("point count out of range during ordering");

  a_fp_done_wait: assert property (@(posedge clk) disable iff (rst)
    fp_rsp.done |-> (state == S_UPD_SUBW) || (state == S_UPD_MULW))
    else $error("float result with no one waiting");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && emit_last) |=> (state == S_LOAD) && (used == '0))
    else $error("run did not close after final beat");
`endif

endmodule
`default_nettype wire
